// ===== sv/amgs_pkg.sv =====
// ----------------------------------------------------------------------------
// amgs_pkg: shared definitions for the adjacency matrix graph store
// Operation codes, sequencer states, field widths and the endpoint match
// result that the compare unit hands to the sequencer.
// ----------------------------------------------------------------------------
package amgs_pkg;

	// fixed field widths of the stream items
	localparam int VTX_W       = 4;
	localparam int VCNT_W      = 5;
	localparam int ECNT_OUT_W  = 6;
	localparam int LABEL_OUT_W = 32;
	localparam int OP_W        = 2;

	// parameter defaults
	localparam int DEF_NUM_VERTICES = 16;
	localparam int DEF_MAX_EDGES    = 32;
	localparam int DEF_LABEL_BITS   = 32;

	typedef enum logic [OP_W-1:0] {
		OP_VERTEX_INS = 2'd0,
		OP_EDGE_INS   = 2'd1,
		OP_VERTEX_DEL = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_RESP,
		ST_EMIT
	} state_t;

	// compare unit result for one edge list entry
	typedef struct packed {
		logic touch;   // entry has the key vertex A as an endpoint
		logic dup;     // entry joins key A and key B in either direction
	} match_t;

endpackage

// ===== sv/amgs_edge_ram.sv =====
// ----------------------------------------------------------------------------
// amgs_edge_ram: edge list storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module amgs_edge_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 40,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/amgs_match.sv =====
// ----------------------------------------------------------------------------
// amgs_match: shared endpoint compare unit
// Compares one edge list entry against the key vertices; used by the
// duplicate search on edge insert and by the compaction pass on erase.
// ----------------------------------------------------------------------------
module amgs_match #(
	parameter int ENTRY_W = 40
) (
	input  logic [ENTRY_W-1:0]               entry,
	input  logic [amgs_pkg::VTX_W-1:0]       key_a,
	input  logic [amgs_pkg::VTX_W-1:0]       key_b,
	output amgs_pkg::match_t                 result
);
	import amgs_pkg::*;

	logic [VTX_W-1:0] end_a;
	logic [VTX_W-1:0] end_b;

	// entry layout from the low bit: end A, end B, label
	assign end_a = entry[VTX_W-1:0];
	assign end_b = entry[2*VTX_W-1:VTX_W];

	always_comb begin
		result.touch = (end_a == key_a) || (end_b == key_a);
		result.dup   = ((end_a == key_a) && (end_b == key_b)) ||
		               ((end_a == key_b) && (end_b == key_a));
	end

endmodule

// ===== sv/adjacency_matrix_graph_store.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store: undirected graph store with ordered edge list
// Vertex present bits, an edge list in insertion order and a sequencer that
// walks the list through one shared endpoint compare unit.
// ----------------------------------------------------------------------------
// One item at a time; s_tready is high only between items. A vertex insert,
// an erase of a missing vertex and any request rejected on its range,
// present or full check go from the input transfer through the decode
// state to the load of the count record. An edge insert that passes those
// checks first runs a duplicate search that reads the edge RAM one entry a
// cycle through its registered read port. An erase scans the list through
// the same read port to compact it and load the count record, then sends
// one label record per cycle after it while m_tready stays high.
// A low m_tready holds the sequencer wherever a record has to be loaded.
// Adjacency is held implicitly by the edge list, so there is no matrix to
// clear and no clearing pass after reset. The next input can be taken while
// the final record still waits on m_tready.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store #(
	parameter int NUM_VERTICES = amgs_pkg::DEF_NUM_VERTICES,
	parameter int MAX_EDGES    = amgs_pkg::DEF_MAX_EDGES,
	parameter int LABEL_BITS   = amgs_pkg::DEF_LABEL_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // vertex_a[3:0], vertex_b[7:4], edge_label[39:8]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // status[0], vertex_count[5:1], edge_count[11:6],
	                               // label_out[43:12], zero[47:44]
	output logic        m_tuser,   // is_label[0]
	output logic        m_tlast
);
	import amgs_pkg::*;

	// only vertex indexes that the 4-bit field can name are ever stored
	localparam int NV_EFF  = (NUM_VERTICES < (1 << VTX_W)) ? NUM_VERTICES : (1 << VTX_W);
	localparam int VIDX_W  = (NV_EFF > 2) ? $clog2(NV_EFF) : 1;
	localparam int LAB_W   = (LABEL_BITS < LABEL_OUT_W) ? LABEL_BITS : LABEL_OUT_W;
	localparam int ENTRY_W = LAB_W + 2 * VTX_W;
	localparam int EIDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
	localparam logic [VTX_W:0]  NV_LIM  = (VTX_W + 1)'(NV_EFF);
	localparam logic [ECNT_W-1:0] E_MAX = ECNT_W'(MAX_EDGES);

	state_t state_q, state_d;

	logic [OP_W-1:0]   op_q;
	logic [VTX_W-1:0]  a_q;
	logic [VTX_W-1:0]  b_q;
	logic [LAB_W-1:0]  lab_q;
	logic              err_q;
	logic              dup_q;
	logic [NV_EFF-1:0] present_q;
	logic [VCNT_W-1:0] vtot_q;
	logic [ECNT_W-1:0] etot_q;
	logic [ECNT_W-1:0] rd_idx_q;
	logic [ECNT_W-1:0] wr_idx_q;
	logic              rvalid_s1;
	logic              pend_q;

	logic                   out_valid_q;
	logic                   out_status_q;
	logic                   out_is_label_q;
	logic [VCNT_W-1:0]      out_vcnt_q;
	logic [ECNT_OUT_W-1:0]  out_ecnt_q;
	logic [LABEL_OUT_W-1:0] out_label_q;
	logic                   out_last_q;

	logic               a_ok, b_ok, pres_a, pres_b, full;
	logic               dec_err, dec_scan;
	logic               scan_more, scan_done, out_free, emit_more;
	logic               rd_en, wr_en, load_count, load_label;
	logic [EIDX_W-1:0]  wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [ENTRY_W-1:0] rd_data;
	logic [LABEL_OUT_W-1:0] lab_ext;
	match_t             hit;

	amgs_edge_ram #(
		.DEPTH (MAX_EDGES),
		.WIDTH (ENTRY_W),
		.AW    (EIDX_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_idx_q[EIDX_W-1:0]),
		.rdata (rd_data)
	);

	amgs_match #(
		.ENTRY_W (ENTRY_W)
	) u_match (
		.entry  (rd_data),
		.key_a  (a_q),
		.key_b  (b_q),
		.result (hit)
	);

	// request checks on the latched item
	assign a_ok   = {1'b0, a_q} < NV_LIM;
	assign b_ok   = {1'b0, b_q} < NV_LIM;
	assign pres_a = a_ok && present_q[a_q[VIDX_W-1:0]];
	assign pres_b = b_ok && present_q[b_q[VIDX_W-1:0]];
	assign full   = etot_q >= E_MAX;

	always_comb begin
		dec_err  = 1'b1;
		dec_scan = 1'b0;
		unique case (op_q)
			OP_VERTEX_INS: begin
				dec_err = !a_ok;
			end
			OP_EDGE_INS: begin
				dec_err  = !pres_a || !pres_b || full;
				dec_scan = !dec_err;
			end
			OP_VERTEX_DEL: begin
				dec_err  = !pres_a;
				dec_scan = !dec_err;
			end
			default: begin
				dec_err = 1'b1;
			end
		endcase
	end

	assign scan_more = rd_idx_q < etot_q;
	assign scan_done = !scan_more && !rvalid_s1;
	assign out_free  = !out_valid_q || m_tready;
	assign emit_more = (op_q == OP_VERTEX_DEL) && !err_q && (etot_q != '0);

	always_comb begin
		lab_ext = '0;
		lab_ext[LAB_W-1:0] = rd_data[ENTRY_W-1:2*VTX_W];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = dec_scan ? ST_SCAN : ST_RESP;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) state_d = emit_more ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (!scan_more && (load_label || !pend_q)) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready   = 1'b0;
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = wr_idx_q[EIDX_W-1:0];
		wr_data    = rd_data;
		load_count = 1'b0;
		load_label = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_DECODE: begin
			end
			ST_SCAN: begin
				rd_en = scan_more;
				if (rvalid_s1 && (op_q == OP_VERTEX_DEL) && !hit.touch) begin
					// keep entry, compact toward the head
					wr_en = 1'b1;
				end else if (scan_done && (op_q == OP_EDGE_INS) && !dup_q) begin
					wr_en   = 1'b1;
					wr_addr = etot_q[EIDX_W-1:0];
					wr_data = {lab_q, b_q, a_q};
				end
			end
			ST_RESP: begin
				load_count = out_free;
				rd_en      = out_free && emit_more;
			end
			ST_EMIT: begin
				load_label = pend_q && out_free;
				rd_en      = (!pend_q || load_label) && scan_more;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			err_q     <= 1'b0;
			dup_q     <= 1'b0;
			present_q <= '0;
			vtot_q    <= '0;
			etot_q    <= '0;
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
			rvalid_s1 <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= (state_q == ST_SCAN) && rd_en;
			if (rd_en) rd_idx_q <= rd_idx_q + 1'b1;

			unique case (state_q)
				ST_DECODE: begin
					err_q    <= dec_err;
					dup_q    <= 1'b0;
					rd_idx_q <= '0;
					wr_idx_q <= '0;
					if ((op_q == OP_VERTEX_INS) && a_ok && !pres_a) begin
						present_q[a_q[VIDX_W-1:0]] <= 1'b1;
						vtot_q <= vtot_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (rvalid_s1 && hit.dup) dup_q <= 1'b1;
					if (rvalid_s1 && (op_q == OP_VERTEX_DEL) && !hit.touch) begin
						wr_idx_q <= wr_idx_q + 1'b1;
					end
					if (scan_done) begin
						rd_idx_q <= '0;
						if (op_q == OP_EDGE_INS) begin
							if (dup_q) begin
								err_q <= 1'b1;
							end else begin
								etot_q <= etot_q + 1'b1;
							end
						end else begin
							etot_q <= wr_idx_q;
							present_q[a_q[VIDX_W-1:0]] <= 1'b0;
							vtot_q <= vtot_q - 1'b1;
						end
					end
				end
				ST_RESP, ST_EMIT: begin
					if (rd_en) begin
						pend_q <= 1'b1;
					end else if (load_label) begin
						pend_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// input item latch
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser;
			a_q   <= s_tdata[VTX_W-1:0];
			b_q   <= s_tdata[2*VTX_W-1:VTX_W];
			lab_q <= s_tdata[2*VTX_W +: LAB_W];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_count || load_label) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_count) begin
			out_status_q   <= err_q;
			out_is_label_q <= 1'b0;
			out_vcnt_q     <= vtot_q;
			out_ecnt_q     <= ECNT_OUT_W'(etot_q);
			out_label_q    <= '0;
			out_last_q     <= !emit_more;
		end else if (load_label) begin
			out_status_q   <= 1'b0;
			out_is_label_q <= 1'b1;
			out_vcnt_q     <= vtot_q;
			out_ecnt_q     <= ECNT_OUT_W'(etot_q);
			out_label_q    <= lab_ext;
			// pending label sits at rd_idx_q - 1
			out_last_q     <= !scan_more;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_label_q, out_ecnt_q, out_vcnt_q, out_status_q};
	assign m_tuser  = out_is_label_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== sv/amgs_checker.sv =====
// ----------------------------------------------------------------------------
// amgs_checker: port level checks for the graph store
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module amgs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("result changed while stalled");

	// one item at a time: no back to back input transfers
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// label records only follow a successful erase and carry a nonzero count
	a_label_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[0] && (m_tdata[11:6] != 6'd0))
		else $error("bad label record");

	// an error gives a single count record
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tlast && !m_tuser)
		else $error("error record not final");

endmodule

bind adjacency_matrix_graph_store amgs_checker u_amgs_checker (.*);
